// File: hw/rtl/ccc_pkg.sv
package ccc_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int DIV_W    = 8;

	// set_year, set_month, set_day, set_hour, set_minute, set_second, packed to whole bytes
	localparam int TDATA_W  = 40;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_TICK_DIVIDE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_YEAR_LO     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_YEAR_HI     = 2'd2;

	localparam logic [DIV_W-1:0]   TICK_DIVIDE_RST = 8'd14;
	localparam logic [YEAR_W-1:0]  YEAR_LO_RST     = 14'd2000;
	localparam logic [YEAR_W-1:0]  YEAR_HI_RST     = 14'd2099;
	localparam logic [YEAR_W-1:0]  YEAR_RST        = 14'd2000;
	localparam logic [MONTH_W-1:0] MONTH_RST       = 4'd1;
	localparam logic [DAY_W-1:0]   DAY_RST         = 5'd1;

	// modular inverse of 25 modulo 2**14; a multiple of 25 maps to 0..655
	localparam logic [YEAR_W-1:0] INV25    = 14'd7209;
	localparam logic [YEAR_W-1:0] DIV25_LIM = 14'd655;

	typedef struct packed {
		logic [SECOND_W-1:0] second;
		logic [MINUTE_W-1:0] minute;
		logic [HOUR_W-1:0]   hour;
		logic [DAY_W-1:0]    day;
		logic [MONTH_W-1:0]  month;
		logic [YEAR_W-1:0]   year;
	} stamp_t;

	typedef struct packed {
		logic set_error;
		logic second_advanced;
	} flags_t;

	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [2*YEAR_W-1:0] prod;
		logic                div25;
		prod  = y * {{YEAR_W{1'b0}}, INV25};
		div25 = (prod[YEAR_W-1:0] <= DIV25_LIM);
		// divisible by 4 and not 100, or by 400 (16 and 25)
		return (y[1:0] == 2'd0 && !div25) || (y[3:0] == 4'd0 && div25);
	endfunction

	function automatic logic [DAY_W-1:0] days_in(input logic [YEAR_W-1:0] y,
			input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd2: begin
				len = is_leap(y) ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				len = 5'd30;
			end
			default: begin
				len = 5'd31;
			end
		endcase
		return len;
	endfunction

endpackage

// File: hw/rtl/calendar_clock_counter_core.sv
// Channel   Direction  Payload (lowest bit up)
// s_axis    in         tuser: mode; tdata: year, month, day, hour, minute, second
// m_axis    out        tuser: second_advanced, set_error; tdata: year, month, day,
//                      hour, minute, second
// cfg       in         cfg_index selects tick divide, lowest year or highest year
//
// One item per cycle sustained while m_axis accepts results.
// Item register feeds one pass of prescaler, carry chain and set check into the
// result register; two mod-25 multipliers (current and set year) set the path.
// Reset loads 1 January 2000, 00:00:00 and a cleared prescaler.
// A stalled result holds and the item register fills behind it before s_axis stalls.
module calendar_clock_counter_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [ccc_pkg::TDATA_W-1:0]  s_axis_tdata,  // set year, month, day, hour, minute, second
	input  logic                         s_axis_tuser,  // mode
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [ccc_pkg::TDATA_W-1:0]  m_axis_tdata,  // year, month, day, hour, minute, second now
	output logic [1:0]                   m_axis_tuser,  // second_advanced, set_error
	input  logic                         cfg_we,
	input  logic [ccc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ccc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ccc_pkg::*;

	logic [DIV_W-1:0]  tick_divide_q;
	logic [YEAR_W-1:0] year_lo_q;
	logic [YEAR_W-1:0] year_hi_q;

	logic              valid_s1;
	logic              mode_s1;
	stamp_t            set_s1;

	logic              valid_s2;
	stamp_t            stamp_s2;
	flags_t            flags_s2;

	logic [DIV_W-1:0]  prescale_q;
	stamp_t            now_q;

	logic              advance;
	logic [DIV_W:0]    pre_sum;
	logic              sec_tick;
	stamp_t            carried;
	stamp_t            now_next;
	logic [DIV_W-1:0]  prescale_next;
	logic              set_ok;
	logic [DAY_W-1:0]  set_feb_max;
	flags_t            flags_next;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_divide_q <= TICK_DIVIDE_RST;
			year_lo_q     <= YEAR_LO_RST;
			year_hi_q     <= YEAR_HI_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TICK_DIVIDE: tick_divide_q <= cfg_data[DIV_W-1:0];
				REG_YEAR_LO:     year_lo_q     <= cfg_data[YEAR_W-1:0];
				REG_YEAR_HI:     year_hi_q     <= cfg_data[YEAR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1 <= s_axis_tuser;
			set_s1  <= s_axis_tdata;
		end
	end

	// prescaler and carry chain
	always_comb begin
		pre_sum  = {1'b0, prescale_q} + 9'd1;
		sec_tick = (pre_sum >= {1'b0, tick_divide_q});
		carried  = now_q;
		if (now_q.second < 6'd59) begin
			carried.second = now_q.second + 6'd1;
		end else begin
			carried.second = '0;
			if (now_q.minute < 6'd59) begin
				carried.minute = now_q.minute + 6'd1;
			end else begin
				carried.minute = '0;
				if (now_q.hour < 5'd23) begin
					carried.hour = now_q.hour + 5'd1;
				end else begin
					carried.hour = '0;
					if (now_q.day < days_in(now_q.year, now_q.month)) begin
						carried.day = now_q.day + 5'd1;
					end else begin
						carried.day = DAY_RST;
						if (now_q.month < 4'd12) begin
							carried.month = now_q.month + 4'd1;
						end else begin
							carried.month = MONTH_RST;
							carried.year  = (now_q.year >= year_hi_q) ? year_lo_q
								: now_q.year + 14'd1;
						end
					end
				end
			end
		end
	end

	// set range check; only February is held to its month length
	always_comb begin
		set_feb_max = is_leap(set_s1.year) ? 5'd29 : 5'd28;
		set_ok = (set_s1.year >= year_lo_q) && (set_s1.year <= year_hi_q)
			&& (set_s1.month >= 4'd1) && (set_s1.month <= 4'd12)
			&& (set_s1.day >= 5'd1) && (set_s1.hour <= 5'd23)
			&& (set_s1.minute <= 6'd59) && (set_s1.second <= 6'd59)
			&& !(set_s1.month == 4'd2 && set_s1.day > set_feb_max);
	end

	always_comb begin
		now_next      = now_q;
		prescale_next = prescale_q;
		flags_next    = '0;
		if (!mode_s1) begin
			if (sec_tick) begin
				prescale_next              = '0;
				now_next                   = carried;
				flags_next.second_advanced = 1'b1;
			end else begin
				prescale_next = pre_sum[DIV_W-1:0];
			end
		end else if (set_ok) begin
			now_next = set_s1;
		end else begin
			flags_next.set_error = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			now_q      <= '{second: '0, minute: '0, hour: '0, day: DAY_RST,
				month: MONTH_RST, year: YEAR_RST};
		end else if (advance) begin
			prescale_q <= prescale_next;
			now_q      <= now_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stamp_s2 <= now_next;
			flags_s2 <= flags_next;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = stamp_s2;
	assign m_axis_tuser  = flags_s2;

endmodule

// File: hw/rtl/ccc_checker.sv
module ccc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [ccc_pkg::TDATA_W-1:0]   m_axis_tdata,
	input  logic [1:0]                    m_axis_tuser
);
	import ccc_pkg::*;

	stamp_t out_stamp;
	flags_t out_flags;

	assign out_stamp = m_axis_tdata;
	assign out_flags = m_axis_tuser;

	// a tick never reports a set error and a set never advances the second
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(out_flags.second_advanced && out_flags.set_error))
		else $error("result flags both set");

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_stamp.month >= 4'd1 && out_stamp.month <= 4'd12
			&& out_stamp.day >= 5'd1)
		else $error("date out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_stamp.hour <= 5'd23 && out_stamp.minute <= 6'd59
			&& out_stamp.second <= 6'd59)
		else $error("time out of range");

	// an advanced second is one past the last shown second, or a wrap to zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready ##1 m_axis_tvalid && out_flags.second_advanced
			|-> out_stamp.second == 6'd0
			|| out_stamp.second == $past(out_stamp.second) + 6'd1)
		else $error("second advanced by other than one");

endmodule

bind calendar_clock_counter_core ccc_checker u_ccc_checker (.*);
